@@ sv/rdc_pkg.sv @@
// Shared constants for the range distinct count block.
// No dependencies; imported by range_distinct_count.
package rdc_pkg;

   localparam int DEF_POSITIONS = 4096;
   localparam int DEF_VALUES    = 4096;

   localparam int KIND_W  = 2;
   localparam int FIELD_W = 12;
   localparam int COUNT_W = 13;

   localparam logic [KIND_W-1:0] KIND_ELEMENT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

endpackage

@@ sv/range_distinct_count.sv @@
// Range distinct count: element items take the next position and move the
// mark of their value to it; query items count the marks in a position range.
//
// Input channel: an item is taken at a rising edge with start high and busy
// low. req_type selects element, range query or restart; any other code is
// dropped. Element and restart items give no result; a query gives one
// result, shown on rsp_distinct_count for one cycle with rsp_strobe high.
// The receiver cannot stall, so a result is never held.
//
// An element holds busy for a last-seen lookup plus one tree walk, and for
// two walks when its value was seen before. A query alternates between
// ST_QUERY_A and ST_QUERY_B once per tree level and raises the strobe as
// it returns to idle; a query with an empty range answers zero in the
// cycle after it is taken. The single read port of the tree memory sets
// this pacing.
//
// Reset and restart items both run a clearing pass over addresses 0 to
// max(2*POSITIONS, VALUES)-1 of the memories with busy high.
module range_distinct_count
   import rdc_pkg::*;
#(
   parameter int POSITIONS = DEF_POSITIONS,
   parameter int VALUES    = DEF_VALUES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [KIND_W-1:0]  req_type,
   input  logic [FIELD_W-1:0] req_value,
   input  logic [FIELD_W-1:0] req_left_index,
   input  logic [FIELD_W-1:0] req_right_index,
   output logic               rsp_strobe,
   output logic [COUNT_W-1:0] rsp_distinct_count
);

   localparam int TREE_N = 2 * POSITIONS;
   localparam int TAW    = $clog2(TREE_N);        // tree address
   localparam int TW     = $clog2(TREE_N + 1);    // query bounds, up to 2*POSITIONS
   localparam int SW     = $clog2(POSITIONS + 1); // node sums
   localparam int PW     = $clog2(POSITIONS);     // position
   localparam int NW     = $clog2(POSITIONS + 1); // next position, up to capacity
   localparam int VW     = $clog2(VALUES);
   localparam int LSW    = PW + 1;                // valid bit plus position
   localparam int CLR_N  = (TREE_N > VALUES) ? TREE_N : VALUES;
   localparam int CLW    = $clog2(CLR_N);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LS_WAIT,
      ST_WALK,
      ST_QUERY_A,
      ST_QUERY_B
   } state_type;

   state_type          state_ff, state_in;
   logic [CLW-1:0]     clr_ff, clr_in;
   logic [NW-1:0]      next_pos_ff, next_pos_in;
   logic [VW-1:0]      val_ff, val_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [TAW-1:0]     k_ff, k_in;
   logic [TAW-1:0]     wk_ff, wk_in;
   logic               wpend_ff, wpend_in;
   logic               dec_ff, dec_in;
   logic               second_ff, second_in;
   logic [TW-1:0]      a_ff, a_in;
   logic [TW-1:0]      b_ff, b_in;
   logic [SW-1:0]      sum_ff, sum_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               tr_we, tr_re;
   logic [TAW-1:0]     tr_waddr, tr_raddr;
   logic [SW-1:0]      tr_wdata, tr_rdata;
   logic               ls_we, ls_re;
   logic [VW-1:0]      ls_waddr, ls_raddr;
   logic [LSW-1:0]     ls_wdata, ls_rdata;

   logic               accept;
   logic [PW-1:0]      rgt_c;
   logic [SW-1:0]      acc;
   logic [TW-1:0]      b_dec;

   rdc_ram #(.WIDTH(SW), .DEPTH(TREE_N)) u_tree (
      .clock   (clock),
      .wr_en   (tr_we),
      .wr_addr (tr_waddr),
      .wr_data (tr_wdata),
      .rd_en   (tr_re),
      .rd_addr (tr_raddr),
      .rd_data (tr_rdata)
   );

   rdc_ram #(.WIDTH(LSW), .DEPTH(VALUES)) u_last_seen (
      .clock   (clock),
      .wr_en   (ls_we),
      .wr_addr (ls_waddr),
      .wr_data (ls_wdata),
      .rd_en   (ls_re),
      .rd_addr (ls_raddr),
      .rd_data (ls_rdata)
   );

   assign busy               = (state_ff != ST_IDLE);
   assign accept             = start && !busy;
   assign rsp_strobe         = rsp_valid_ff;
   assign rsp_distinct_count = rsp_count_ff;

   assign rgt_c = (32'(req_right_index) > 32'(POSITIONS - 1)) ?
                  PW'(POSITIONS - 1) : PW'(req_right_index);
   assign acc   = sum_ff + (pend_ff ? tr_rdata : '0);
   assign b_dec = b_ff - TW'(1);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      next_pos_in  = next_pos_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      wk_in        = wk_ff;
      wpend_in     = wpend_ff;
      dec_in       = dec_ff;
      second_in    = second_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      sum_in       = sum_ff;
      pend_in      = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;

      tr_we    = 1'b0;
      tr_waddr = wk_ff;
      tr_wdata = dec_ff ? (tr_rdata - SW'(1)) : (tr_rdata + SW'(1));
      tr_re    = 1'b0;
      tr_raddr = k_ff;
      ls_we    = 1'b0;
      ls_waddr = val_ff;
      ls_wdata = {1'b1, pos_ff};
      ls_re    = 1'b0;
      ls_raddr = VW'(req_value);

      unique case (state_ff)
         ST_CLEAR: begin
            tr_we    = (32'(clr_ff) < 32'(TREE_N));
            tr_waddr = TAW'(clr_ff);
            tr_wdata = '0;
            ls_we    = (32'(clr_ff) < 32'(VALUES));
            ls_waddr = VW'(clr_ff);
            ls_wdata = '0;
            clr_in   = clr_ff + CLW'(1);
            if (clr_ff == CLW'(CLR_N - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  KIND_ELEMENT: begin
                     // drop elements past capacity or out of the value range
                     if ((next_pos_ff != NW'(POSITIONS)) &&
                         (32'(req_value) < 32'(VALUES))) begin
                        ls_re    = 1'b1;
                        val_in   = VW'(req_value);
                        pos_in   = PW'(next_pos_ff);
                        state_in = ST_LS_WAIT;
                     end
                  end
                  KIND_QUERY: begin
                     if (32'(req_left_index) > 32'(rgt_c)) begin
                        rsp_valid_in = 1'b1;
                        rsp_count_in = '0;
                     end else begin
                        a_in     = TW'(req_left_index) + TW'(POSITIONS);
                        b_in     = TW'(rgt_c) + TW'(POSITIONS + 1);
                        sum_in   = '0;
                        pend_in  = 1'b0;
                        state_in = ST_QUERY_A;
                     end
                  end
                  KIND_RESTART: begin
                     clr_in      = '0;
                     next_pos_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LS_WAIT: begin
            ls_we    = 1'b1;
            wpend_in = 1'b0;
            if (ls_rdata[LSW-1]) begin
               // clear the old mark first, then set the new one
               k_in      = TAW'(ls_rdata[PW-1:0]) + TAW'(POSITIONS);
               dec_in    = 1'b1;
               second_in = 1'b1;
            end else begin
               k_in      = TAW'(pos_ff) + TAW'(POSITIONS);
               dec_in    = 1'b0;
               second_in = 1'b0;
            end
            state_in = ST_WALK;
         end
         ST_WALK: begin
            // read a node while writing back its child one level below
            tr_we = wpend_ff;
            if (k_ff != '0) begin
               tr_re    = 1'b1;
               wk_in    = k_ff;
               wpend_in = 1'b1;
               k_in     = k_ff >> 1;
            end else begin
               wpend_in = 1'b0;
               if (second_ff) begin
                  k_in      = TAW'(pos_ff) + TAW'(POSITIONS);
                  dec_in    = 1'b0;
                  second_in = 1'b0;
               end else begin
                  next_pos_in = next_pos_ff + NW'(1);
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_QUERY_A: begin
            sum_in = acc;
            if (a_ff < b_ff) begin
               tr_raddr = TAW'(a_ff);
               tr_re    = a_ff[0];
               pend_in  = a_ff[0];
               if (a_ff[0]) begin
                  a_in = a_ff + TW'(1);
               end
               state_in = ST_QUERY_B;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_count_in = COUNT_W'(acc);
               pend_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_QUERY_B: begin
            sum_in   = acc;
            tr_raddr = TAW'(b_dec);
            tr_re    = b_ff[0];
            pend_in  = b_ff[0];
            b_in     = b_ff[0] ? (b_dec >> 1) : (b_ff >> 1);
            a_in     = a_ff >> 1;
            state_in = ST_QUERY_A;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         next_pos_ff  <= '0;
         wpend_ff     <= 1'b0;
         second_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_pos_ff  <= next_pos_in;
         wpend_ff     <= wpend_in;
         second_ff    <= second_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff       <= val_in;
      pos_ff       <= pos_in;
      k_ff         <= k_in;
      wk_ff        <= wk_in;
      dec_ff       <= dec_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      sum_ff       <= sum_in;
      rsp_count_ff <= rsp_count_in;
   end

   // a tree node is never read in the cycle it is written back
   a_tree_rw_apart: assert property (@(posedge clock) disable iff (reset)
      (tr_we && tr_re) |-> (tr_waddr != tr_raddr))
      else $error("tree read and write hit the same node");

   a_next_pos_bound: assert property (@(posedge clock) disable iff (reset)
      32'(next_pos_ff) <= 32'(POSITIONS))
      else $error("next position beyond capacity");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result during clearing pass");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == KIND_RESTART)) |=> (busy && (next_pos_ff == '0)))
      else $error("restart did not start clearing");

endmodule

@@ sv/rdc_ram.sv @@
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies; used for the last-seen table and the segment sum tree.
module rdc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
